// ----- sv/gtp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gtp_pkg;

  // Number format and output range.
  localparam int FRAC_BITS = 30;
  localparam int OUT_WIDTH = 48;
  localparam int IN_W      = 32;

  // Widths of the intermediate terms.
  localparam int PROD_W   = 2 * IN_W;
  localparam int P_W      = PROD_W + 1;
  localparam int D_W      = PROD_W + 2;
  localparam int N2_W     = PROD_W;
  localparam int ROOT_W   = N2_W / 2;
  localparam int SQ_STEPS = ROOT_W;
  localparam int SQ_REM_W = ROOT_W + 2;
  localparam int HALF_W   = IN_W;
  localparam int NXP_W    = PROD_W + IN_W;
  localparam int NUMX_W   = NXP_W + 2;
  localparam int DEN_W    = ROOT_W + PROD_W;
  localparam int DEN_SW   = DEN_W + 1;
  localparam int Q_W      = OUT_WIDTH;
  localparam int REM_A    = NUMX_W + FRAC_BITS;
  localparam int REM_B    = DEN_W + OUT_WIDTH;
  localparam int REM_W    = ((REM_A > REM_B) ? REM_A : REM_B) + 1;

  // Stream widths.
  localparam int S_DATA_W = ((6 * IN_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((2 * OUT_WIDTH + 7) / 8) * 8;
  localparam int USER_W   = 2;

  // Bit positions in the result tuser.
  localparam int USER_BEHIND = 0;
  localparam int USER_SAT    = 1;

  // Pole markers and saturation limits.
  localparam logic signed [IN_W-1:0] ONE       = IN_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [IN_W-1:0] MINUS_ONE = -ONE;
  localparam logic [Q_W-1:0] POS_LIMIT = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] NEG_LIMIT = {1'b1, {(Q_W-1){1'b0}}};

endpackage

`default_nettype wire

// ----- sv/gnomonic_tangent_projection.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Gnomonic tangent-plane projection of a star unit vector about a projection
// centre, all in signed fixed point with 30 fraction bits. One item is taken
// every clock; the length from acceptance to result is set by the 32-stage
// square-root pipeline and the two 48-stage restoring dividers that run side
// by side. When the output is stalled the whole pipeline holds. A star with
// non-positive dot product against the centre returns zero coordinates with
// the behind flag set; coordinates beyond the 48-bit range are clipped and
// flagged as saturated.
module gnomonic_tangent_projection (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // star_x, star_y, star_z, centre_x, centre_y, centre_z (32 bits each)
  input  wire logic [gtp_pkg::S_DATA_W-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // plane_x, plane_y (48 bits each)
  output logic [gtp_pkg::M_DATA_W-1:0]       m_axis_tdata,
  // behind_centre, saturated
  output logic [gtp_pkg::USER_W-1:0]         m_axis_tuser
);

  typedef struct packed {
    logic [gtp_pkg::N2_W-1:0]          n2;
    logic [gtp_pkg::PROD_W-1:0]        p_mag;
    logic                              p_neg;
    logic [gtp_pkg::PROD_W-1:0]        d_lo;
    logic signed [gtp_pkg::P_W-1:0]    numy;
    logic signed [gtp_pkg::IN_W-1:0]   sx;
    logic signed [gtp_pkg::IN_W-1:0]   sz;
    logic [gtp_pkg::IN_W-1:0]          sz_mag;
    logic                              sz_neg;
    logic [gtp_pkg::IN_W-1:0]          rz_mag;
    logic                              rz_neg;
    logic                              pole;
    logic                              behind;
  } sq_carry_t;

  typedef struct packed {
    logic signed [gtp_pkg::P_W-1:0]    numy;
    logic signed [gtp_pkg::IN_W-1:0]   sx;
    logic signed [gtp_pkg::IN_W-1:0]   sz;
    logic                              pole;
    logic                              behind;
    logic                              a_neg;
    logic                              b_neg;
  } post_t;

  typedef struct packed {
    logic [gtp_pkg::DEN_W-1:0] dm;
    logic                      neg_x;
    logic                      neg_y;
    logic                      over_x;
    logic                      over_y;
    logic                      zero_x;
    logic                      zero_y;
    logic                      behind;
  } dv_ctl_t;

  logic en;

  // Input field unpacking.
  logic signed [gtp_pkg::IN_W-1:0] in_sx, in_sy, in_sz, in_rx, in_ry, in_rz;
  assign in_sx = $signed(s_axis_tdata[0*gtp_pkg::IN_W +: gtp_pkg::IN_W]);
  assign in_sy = $signed(s_axis_tdata[1*gtp_pkg::IN_W +: gtp_pkg::IN_W]);
  assign in_sz = $signed(s_axis_tdata[2*gtp_pkg::IN_W +: gtp_pkg::IN_W]);
  assign in_rx = $signed(s_axis_tdata[3*gtp_pkg::IN_W +: gtp_pkg::IN_W]);
  assign in_ry = $signed(s_axis_tdata[4*gtp_pkg::IN_W +: gtp_pkg::IN_W]);
  assign in_rz = $signed(s_axis_tdata[5*gtp_pkg::IN_W +: gtp_pkg::IN_W]);

  // The pipeline advances whenever the output register can move.
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: the seven component products.
  logic v1;
  logic signed [gtp_pkg::PROD_W-1:0] s1_sxrx, s1_syry, s1_szrz, s1_rxrx, s1_ryry;
  logic signed [gtp_pkg::PROD_W-1:0] s1_syrx, s1_sxry;
  logic signed [gtp_pkg::IN_W-1:0]   s1_sx, s1_sy, s1_sz, s1_rz;
  logic                              s1_pole;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
    end
    if (en) begin
      s1_sxrx <= in_sx * in_rx;
      s1_syry <= in_sy * in_ry;
      s1_szrz <= in_sz * in_rz;
      s1_rxrx <= in_rx * in_rx;
      s1_ryry <= in_ry * in_ry;
      s1_syrx <= in_sy * in_rx;
      s1_sxry <= in_sx * in_ry;
      s1_sx   <= in_sx;
      s1_sy   <= in_sy;
      s1_sz   <= in_sz;
      s1_rz   <= in_rz;
      s1_pole <= (in_rz == gtp_pkg::ONE) || (in_rz == gtp_pkg::MINUS_ONE);
    end
  end

  // Stage 2: partial dot product, squared centre length, y numerator.
  logic v2;
  logic signed [gtp_pkg::P_W-1:0]    s2_p, s2_numy;
  logic [gtp_pkg::N2_W-1:0]          s2_n2;
  logic signed [gtp_pkg::PROD_W-1:0] s2_szrz;
  logic signed [gtp_pkg::IN_W-1:0]   s2_sx, s2_sy, s2_sz, s2_rz;
  logic                              s2_pole;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      s2_p    <= gtp_pkg::P_W'(s1_sxrx) + gtp_pkg::P_W'(s1_syry);
      s2_n2   <= $unsigned(s1_rxrx) + $unsigned(s1_ryry);
      s2_numy <= gtp_pkg::P_W'(s1_syrx) - gtp_pkg::P_W'(s1_sxry);
      s2_szrz <= s1_szrz;
      s2_sx   <= s1_sx;
      s2_sy   <= s1_sy;
      s2_sz   <= s1_sz;
      s2_rz   <= s1_rz;
      s2_pole <= s1_pole;
    end
  end

  // Stage 3: full dot product, behind test, magnitudes for later products.
  logic signed [gtp_pkg::D_W-1:0] s3_d;
  logic signed [gtp_pkg::P_W-1:0] s3_p_abs, s3_sy_ext;
  sq_carry_t                      s3_c;

  always_comb begin
    s3_d      = gtp_pkg::D_W'(s2_p) + gtp_pkg::D_W'(s2_szrz);
    s3_p_abs  = s2_p[gtp_pkg::P_W-1] ? -s2_p : s2_p;
    s3_sy_ext = gtp_pkg::P_W'(s2_sy);
    s3_c.n2     = s2_n2;
    s3_c.p_mag  = s3_p_abs[gtp_pkg::PROD_W-1:0];
    s3_c.p_neg  = s2_p[gtp_pkg::P_W-1];
    s3_c.d_lo   = s3_d[gtp_pkg::PROD_W-1:0];
    s3_c.numy   = s2_pole ? (s2_rz[gtp_pkg::IN_W-1] ? -s3_sy_ext : s3_sy_ext) : s2_numy;
    s3_c.sx     = s2_sx;
    s3_c.sz     = s2_sz;
    s3_c.sz_mag = s2_sz[gtp_pkg::IN_W-1] ? $unsigned(-s2_sz) : $unsigned(s2_sz);
    s3_c.sz_neg = s2_sz[gtp_pkg::IN_W-1];
    s3_c.rz_mag = s2_rz[gtp_pkg::IN_W-1] ? $unsigned(-s2_rz) : $unsigned(s2_rz);
    s3_c.rz_neg = s2_rz[gtp_pkg::IN_W-1];
    s3_c.pole   = s2_pole;
    s3_c.behind = s3_d[gtp_pkg::D_W-1] || (s3_d == '0);
  end

  // Square-root pipeline: entry 0 is stage 3, then one root bit per stage.
  logic                          sq_v    [gtp_pkg::SQ_STEPS+1];
  sq_carry_t                     sq_c    [gtp_pkg::SQ_STEPS+1];
  logic [gtp_pkg::SQ_REM_W-1:0]  sq_rem  [gtp_pkg::SQ_STEPS+1];
  logic [gtp_pkg::ROOT_W-1:0]    sq_root [gtp_pkg::SQ_STEPS+1];
  logic [gtp_pkg::SQ_REM_W-1:0]  sq_rem_next  [gtp_pkg::SQ_STEPS];
  logic [gtp_pkg::ROOT_W-1:0]    sq_root_next [gtp_pkg::SQ_STEPS];

  always_comb begin
    logic [gtp_pkg::SQ_REM_W-1:0] rin;
    logic [gtp_pkg::SQ_REM_W-1:0] trial;
    for (int k = 0; k < gtp_pkg::SQ_STEPS; k++) begin
      rin   = {sq_rem[k][gtp_pkg::SQ_REM_W-3:0],
               sq_c[k].n2[2*(gtp_pkg::SQ_STEPS-1-k) +: 2]};
      trial = {sq_root[k], 2'b01};
      if (rin >= trial) begin
        sq_rem_next[k]  = rin - trial;
        sq_root_next[k] = {sq_root[k][gtp_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem_next[k]  = rin;
        sq_root_next[k] = {sq_root[k][gtp_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= gtp_pkg::SQ_STEPS; k++) begin
        sq_v[k] <= 1'b0;
      end
    end else if (en) begin
      sq_v[0] <= v2;
      for (int k = 0; k < gtp_pkg::SQ_STEPS; k++) begin
        sq_v[k+1] <= sq_v[k];
      end
    end
    if (en) begin
      sq_c[0]    <= s3_c;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      for (int k = 0; k < gtp_pkg::SQ_STEPS; k++) begin
        sq_c[k+1]    <= sq_c[k];
        sq_rem[k+1]  <= sq_rem_next[k];
        sq_root[k+1] <= sq_root_next[k];
      end
    end
  end

  // Stage 4: 32 by 32 partial products of the denominator and x numerator.
  sq_carry_t                  sq_out;
  logic [gtp_pkg::ROOT_W-1:0] root;
  assign sq_out = sq_c[gtp_pkg::SQ_STEPS];
  assign root   = sq_root[gtp_pkg::SQ_STEPS];

  logic v4;
  logic [gtp_pkg::PROD_W-1:0] s4_den_lo, s4_den_hi, s4_a_lo, s4_a_hi, s4_b_lo, s4_b_hi;
  post_t                      s4_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= sq_v[gtp_pkg::SQ_STEPS];
    end
    if (en) begin
      s4_den_lo <= {{(gtp_pkg::PROD_W-gtp_pkg::ROOT_W){1'b0}}, root}
                 * {{gtp_pkg::HALF_W{1'b0}}, sq_out.d_lo[gtp_pkg::HALF_W-1:0]};
      s4_den_hi <= {{(gtp_pkg::PROD_W-gtp_pkg::ROOT_W){1'b0}}, root}
                 * {{gtp_pkg::HALF_W{1'b0}}, sq_out.d_lo[gtp_pkg::PROD_W-1:gtp_pkg::HALF_W]};
      s4_a_lo   <= {{gtp_pkg::HALF_W{1'b0}}, sq_out.n2[gtp_pkg::HALF_W-1:0]}
                 * {{gtp_pkg::HALF_W{1'b0}}, sq_out.sz_mag};
      s4_a_hi   <= {{gtp_pkg::HALF_W{1'b0}}, sq_out.n2[gtp_pkg::N2_W-1:gtp_pkg::HALF_W]}
                 * {{gtp_pkg::HALF_W{1'b0}}, sq_out.sz_mag};
      s4_b_lo   <= {{gtp_pkg::HALF_W{1'b0}}, sq_out.p_mag[gtp_pkg::HALF_W-1:0]}
                 * {{gtp_pkg::HALF_W{1'b0}}, sq_out.rz_mag};
      s4_b_hi   <= {{gtp_pkg::HALF_W{1'b0}}, sq_out.p_mag[gtp_pkg::PROD_W-1:gtp_pkg::HALF_W]}
                 * {{gtp_pkg::HALF_W{1'b0}}, sq_out.rz_mag};
      s4_c.numy   <= sq_out.numy;
      s4_c.sx     <= sq_out.sx;
      s4_c.sz     <= sq_out.sz;
      s4_c.pole   <= sq_out.pole;
      s4_c.behind <= sq_out.behind;
      s4_c.a_neg  <= sq_out.sz_neg;
      s4_c.b_neg  <= sq_out.p_neg ^ sq_out.rz_neg;
    end
  end

  // Stage 5: combine the partial products.
  logic v5;
  logic [gtp_pkg::DEN_W-1:0] s5_den;
  logic [gtp_pkg::NXP_W-1:0] s5_a, s5_b;
  post_t                     s5_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      s5_den <= (gtp_pkg::DEN_W'(s4_den_hi) << gtp_pkg::HALF_W) + gtp_pkg::DEN_W'(s4_den_lo);
      s5_a   <= (gtp_pkg::NXP_W'(s4_a_hi) << gtp_pkg::HALF_W) + gtp_pkg::NXP_W'(s4_a_lo);
      s5_b   <= (gtp_pkg::NXP_W'(s4_b_hi) << gtp_pkg::HALF_W) + gtp_pkg::NXP_W'(s4_b_lo);
      s5_c   <= s4_c;
    end
  end

  // Stage 6: signed numerators and denominator, pole or general case.
  logic signed [gtp_pkg::NUMX_W-1:0] s6_sa, s6_sb;
  always_comb begin
    s6_sa = $signed({2'b00, s5_a});
    s6_sb = $signed({2'b00, s5_b});
    if (s5_c.a_neg) s6_sa = -s6_sa;
    if (s5_c.b_neg) s6_sb = -s6_sb;
  end

  logic v6;
  logic signed [gtp_pkg::NUMX_W-1:0] s6_num_x, s6_num_y;
  logic signed [gtp_pkg::DEN_SW-1:0] s6_den;
  logic                              s6_behind;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
    if (en) begin
      s6_num_x  <= s5_c.pole ? gtp_pkg::NUMX_W'(s5_c.sx) : (s6_sa - s6_sb);
      s6_num_y  <= gtp_pkg::NUMX_W'(s5_c.numy);
      s6_den    <= s5_c.pole ? gtp_pkg::DEN_SW'(s5_c.sz) : $signed({1'b0, s5_den});
      s6_behind <= s5_c.behind;
    end
  end

  // Stage 7: magnitudes and quotient signs.
  logic signed [gtp_pkg::NUMX_W-1:0] s7_ax, s7_ay;
  logic signed [gtp_pkg::DEN_SW-1:0] s7_ad;
  assign s7_ax = s6_num_x[gtp_pkg::NUMX_W-1] ? -s6_num_x : s6_num_x;
  assign s7_ay = s6_num_y[gtp_pkg::NUMX_W-1] ? -s6_num_y : s6_num_y;
  assign s7_ad = s6_den[gtp_pkg::DEN_SW-1] ? -s6_den : s6_den;

  logic v7;
  logic [gtp_pkg::NUMX_W-1:0] s7_nx, s7_ny;
  dv_ctl_t                    s7_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
    if (en) begin
      s7_nx         <= $unsigned(s7_ax);
      s7_ny         <= $unsigned(s7_ay);
      s7_ctl.dm     <= s7_ad[gtp_pkg::DEN_W-1:0];
      s7_ctl.neg_x  <= s6_num_x[gtp_pkg::NUMX_W-1] ^ s6_den[gtp_pkg::DEN_SW-1];
      s7_ctl.neg_y  <= s6_num_y[gtp_pkg::NUMX_W-1] ^ s6_den[gtp_pkg::DEN_SW-1];
      s7_ctl.over_x <= 1'b0;
      s7_ctl.over_y <= 1'b0;
      s7_ctl.zero_x <= (s6_num_x == '0);
      s7_ctl.zero_y <= (s6_num_y == '0);
      s7_ctl.behind <= s6_behind;
    end
  end

  // Stage 8: scaled dividends and overflow thresholds (limit + 1) * divisor.
  logic v8;
  logic [gtp_pkg::REM_W-1:0] s8_nx, s8_ny, s8_thr_x, s8_thr_y;
  dv_ctl_t                   s8_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
    if (en) begin
      s8_nx    <= gtp_pkg::REM_W'(s7_nx) << gtp_pkg::FRAC_BITS;
      s8_ny    <= gtp_pkg::REM_W'(s7_ny) << gtp_pkg::FRAC_BITS;
      s8_thr_x <= (gtp_pkg::REM_W'(s7_ctl.dm) << (gtp_pkg::OUT_WIDTH - 1))
                + (s7_ctl.neg_x ? gtp_pkg::REM_W'(s7_ctl.dm) : '0);
      s8_thr_y <= (gtp_pkg::REM_W'(s7_ctl.dm) << (gtp_pkg::OUT_WIDTH - 1))
                + (s7_ctl.neg_y ? gtp_pkg::REM_W'(s7_ctl.dm) : '0);
      s8_ctl   <= s7_ctl;
    end
  end

  // Divider pipelines: entry 0 holds the overflow compare, then one
  // quotient bit per stage for both coordinates.
  logic                      dv_v   [gtp_pkg::Q_W+1];
  dv_ctl_t                   dv_ctl [gtp_pkg::Q_W+1];
  logic [gtp_pkg::REM_W-1:0] dv_rx  [gtp_pkg::Q_W+1];
  logic [gtp_pkg::REM_W-1:0] dv_ry  [gtp_pkg::Q_W+1];
  logic [gtp_pkg::Q_W-1:0]   dv_qx  [gtp_pkg::Q_W+1];
  logic [gtp_pkg::Q_W-1:0]   dv_qy  [gtp_pkg::Q_W+1];
  logic [gtp_pkg::REM_W-1:0] dv_rx_next [gtp_pkg::Q_W];
  logic [gtp_pkg::REM_W-1:0] dv_ry_next [gtp_pkg::Q_W];
  logic [gtp_pkg::Q_W-1:0]   dv_qx_next [gtp_pkg::Q_W];
  logic [gtp_pkg::Q_W-1:0]   dv_qy_next [gtp_pkg::Q_W];

  dv_ctl_t s8_ctl_over;
  always_comb begin
    s8_ctl_over        = s8_ctl;
    s8_ctl_over.over_x = (s8_nx >= s8_thr_x);
    s8_ctl_over.over_y = (s8_ny >= s8_thr_y);
  end

  always_comb begin
    logic [gtp_pkg::REM_W-1:0] trial;
    for (int j = 0; j < gtp_pkg::Q_W; j++) begin
      trial = gtp_pkg::REM_W'(dv_ctl[j].dm) << (gtp_pkg::Q_W - 1 - j);
      if (dv_rx[j] >= trial) begin
        dv_rx_next[j] = dv_rx[j] - trial;
        dv_qx_next[j] = dv_qx[j] | (gtp_pkg::Q_W'(1) << (gtp_pkg::Q_W - 1 - j));
      end else begin
        dv_rx_next[j] = dv_rx[j];
        dv_qx_next[j] = dv_qx[j];
      end
      if (dv_ry[j] >= trial) begin
        dv_ry_next[j] = dv_ry[j] - trial;
        dv_qy_next[j] = dv_qy[j] | (gtp_pkg::Q_W'(1) << (gtp_pkg::Q_W - 1 - j));
      end else begin
        dv_ry_next[j] = dv_ry[j];
        dv_qy_next[j] = dv_qy[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= gtp_pkg::Q_W; j++) begin
        dv_v[j] <= 1'b0;
      end
    end else if (en) begin
      dv_v[0] <= v8;
      for (int j = 0; j < gtp_pkg::Q_W; j++) begin
        dv_v[j+1] <= dv_v[j];
      end
    end
    if (en) begin
      dv_ctl[0] <= s8_ctl_over;
      dv_rx[0]  <= s8_nx;
      dv_ry[0]  <= s8_ny;
      dv_qx[0]  <= '0;
      dv_qy[0]  <= '0;
      for (int j = 0; j < gtp_pkg::Q_W; j++) begin
        dv_ctl[j+1] <= dv_ctl[j];
        dv_rx[j+1]  <= dv_rx_next[j];
        dv_ry[j+1]  <= dv_ry_next[j];
        dv_qx[j+1]  <= dv_qx_next[j];
        dv_qy[j+1]  <= dv_qy_next[j];
      end
    end
  end

  // Output stage: saturation, sign and the behind case.
  dv_ctl_t                 fin;
  logic [gtp_pkg::Q_W-1:0] mag_x, mag_y, res_x, res_y;
  logic                    sat;

  always_comb begin
    fin = dv_ctl[gtp_pkg::Q_W];
    if (fin.zero_x) mag_x = '0;
    else if (fin.over_x) mag_x = fin.neg_x ? gtp_pkg::NEG_LIMIT : gtp_pkg::POS_LIMIT;
    else mag_x = dv_qx[gtp_pkg::Q_W];
    if (fin.zero_y) mag_y = '0;
    else if (fin.over_y) mag_y = fin.neg_y ? gtp_pkg::NEG_LIMIT : gtp_pkg::POS_LIMIT;
    else mag_y = dv_qy[gtp_pkg::Q_W];
    res_x = fin.neg_x ? -mag_x : mag_x;
    res_y = fin.neg_y ? -mag_y : mag_y;
    sat   = ((fin.over_x && !fin.zero_x) || (fin.over_y && !fin.zero_y));
    if (fin.behind) begin
      res_x = '0;
      res_y = '0;
      sat   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv_v[gtp_pkg::Q_W];
    end
    if (en) begin
      m_axis_tdata <= gtp_pkg::M_DATA_W'({res_y, res_x});
      m_axis_tuser[gtp_pkg::USER_BEHIND] <= fin.behind;
      m_axis_tuser[gtp_pkg::USER_SAT]    <= sat;
    end
  end

endmodule

`default_nettype wire

// ----- sv/gtp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gtp_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_axis_tready,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [gtp_pkg::M_DATA_W-1:0] m_axis_tdata,
  input wire logic [gtp_pkg::USER_W-1:0]   m_axis_tuser
);

  // A star behind the centre gives zero coordinates and no saturation.
  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[gtp_pkg::USER_BEHIND]
      |-> (m_axis_tdata == '0) && !m_axis_tuser[gtp_pkg::USER_SAT])
    else $error("behind item carries nonzero result");

  // An empty output register always lets the input side move.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready
      |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind gnomonic_tangent_projection gtp_checker u_gtp_checker (.*);

`default_nettype wire

// ----- sim/gnomonic_tangent_projection_test.sv -----
`timescale 1ns / 1ps

module gnomonic_tangent_projection_test;

  typedef logic signed [191:0] wide_t;
  typedef logic [191:0] wideu_t;

  typedef struct packed {
    logic [47:0] plane_x;
    logic [47:0] plane_y;
    logic        behind;
    logic        sat;
  } proj_t;

  // Holds the projections still to come back and compares them on arrival.
  class projection_board;
    proj_t pending[$];
    int    errors;
    int    n_behind;
    int    n_sat;
    int    n_pole;
    int    n_checked;

    function longint unsigned root64(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // Truncated num * 2^FRAC_BITS / den, clipped to the output range.
    function logic [47:0] scaled_quot(wide_t num, wide_t den, inout logic sat);
      logic   neg;
      wideu_t nm;
      wideu_t dm;
      wideu_t q;
      wideu_t limit;
      neg = (num < 0) != (den < 0);
      nm = (num < 0) ? -num : num;
      dm = (den < 0) ? -den : den;
      limit = neg ? (wideu_t'(1) << (gtp_pkg::OUT_WIDTH - 1))
                  : (wideu_t'(1) << (gtp_pkg::OUT_WIDTH - 1)) - 1;
      if (nm == 0) return '0;
      if (dm == 0) begin
        sat = 1'b1;
        q = limit;
      end else begin
        q = (nm << gtp_pkg::FRAC_BITS) / dm;
        if (q > limit) begin
          sat = 1'b1;
          q = limit;
        end
      end
      if (neg) q = -q;
      return q[47:0];
    endfunction

    function void note_star(logic [191:0] data);
      wide_t sx, sy, sz, rx, ry, rz, dotxy, dot, n2;
      longint unsigned n;
      wide_t numx, numy, den;
      proj_t e;
      sx = wide_t'(signed'(data[31:0]));
      sy = wide_t'(signed'(data[63:32]));
      sz = wide_t'(signed'(data[95:64]));
      rx = wide_t'(signed'(data[127:96]));
      ry = wide_t'(signed'(data[159:128]));
      rz = wide_t'(signed'(data[191:160]));
      dotxy = sx * rx + sy * ry;
      dot = dotxy + sz * rz;
      e = '0;
      if (dot <= 0) begin
        e.behind = 1'b1;
        n_behind++;
      end else begin
        if (rz == wide_t'(gtp_pkg::ONE) || rz == wide_t'(gtp_pkg::MINUS_ONE)) begin
          n_pole++;
          numx = sx;
          numy = (rz > 0) ? sy : -sy;
          den = sz;
        end else begin
          n2 = rx * rx + ry * ry;
          n = root64(n2[63:0]);
          numx = n2 * sz - dotxy * rz;
          numy = sy * rx - sx * ry;
          den = wide_t'({1'b0, n}) * dot;
        end
        e.plane_x = scaled_quot(numx, den, e.sat);
        e.plane_y = scaled_quot(numy, den, e.sat);
        if (e.sat) n_sat++;
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic [gtp_pkg::M_DATA_W-1:0] data,
                               logic [gtp_pkg::USER_W-1:0] user);
      proj_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result data=%h user=%b", $time, data, user);
        errors++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (data[47:0] !== e.plane_x) begin
        $display("%0t: plane_x expected %h actual %h", $time, e.plane_x, data[47:0]);
        errors++;
      end
      if (data[95:48] !== e.plane_y) begin
        $display("%0t: plane_y expected %h actual %h", $time, e.plane_y, data[95:48]);
        errors++;
      end
      if (user[gtp_pkg::USER_BEHIND] !== e.behind) begin
        $display("%0t: behind expected %b actual %b", $time, e.behind,
                 user[gtp_pkg::USER_BEHIND]);
        errors++;
      end
      if (user[gtp_pkg::USER_SAT] !== e.sat) begin
        $display("%0t: saturated expected %b actual %b", $time, e.sat,
                 user[gtp_pkg::USER_SAT]);
        errors++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [gtp_pkg::S_DATA_W-1:0] s_axis_tdata;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [gtp_pkg::M_DATA_W-1:0] m_axis_tdata;
  logic [gtp_pkg::USER_W-1:0]   m_axis_tuser;

  projection_board board;
  bit              idle_en;
  int              quiet_cycles;

  gnomonic_tangent_projection i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock with a 4 ns period.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    board = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    idle_en = 1'b1;
  end

  // Result side: check every accepted item, then stall at random.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= !(idle_en && $urandom_range(0, 99) < 31);
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rand_comp();
    return 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
  endfunction

  function automatic logic [31:0] nudge(logic [31:0] v, int span);
    longint r;
    r = longint'(signed'(v)) + $urandom_range(0, 2 * span) - span;
    if (r > 64'sh4000_0000) r = 64'sh4000_0000;
    if (r < -64'sh4000_0000) r = -64'sh4000_0000;
    return r[31:0];
  endfunction

  task automatic send_star(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                           logic [31:0] rx, logic [31:0] ry, logic [31:0] rz);
    // Idle cycle by cycle so that about a third of the cycles carry nothing.
    while (idle_en && $urandom_range(0, 99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {rz, ry, rx, sz, sy, sx};
    do @(posedge clk); while (!s_axis_tready);
    board.note_star(s_axis_tdata);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Random item: a centre anywhere, a pole or on the pole axis, and a star
  // that is either close to the centre or anywhere at all.
  task automatic send_random();
    logic [31:0] rx, ry, rz, sx, sy, sz;
    int kind;
    int span;
    kind = $urandom_range(0, 99);
    rx = rand_comp();
    ry = rand_comp();
    rz = rand_comp();
    if (kind < 8) begin
      rx = $signed(rand_comp()) >>> 2;
      ry = $signed(rand_comp()) >>> 2;
      rz = $urandom_range(0, 1) ? gtp_pkg::ONE : gtp_pkg::MINUS_ONE;
    end else if (kind < 12) begin
      rx = '0;
      ry = '0;
    end
    if (kind < 60 || kind >= 90) begin
      span = 1 << $urandom_range(4, 29);
      sx = nudge(rx, span);
      sy = nudge(ry, span);
      sz = nudge(rz, span);
    end else begin
      sx = rand_comp();
      sy = rand_comp();
      sz = rand_comp();
    end
    send_star(sx, sy, sz, rx, ry, rz);
  endtask

  initial begin
    logic [31:0] half;
    logic [31:0] one;
    logic [31:0] minus_one;
    half = gtp_pkg::ONE >>> 1;
    one = gtp_pkg::ONE;
    minus_one = gtp_pkg::MINUS_ONE;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cases.
    send_star('0, '0, '0, '0, '0, '0);                     // zero dot: behind
    send_star(half, half, one, '0, '0, one);               // north pole
    send_star(half, -half, one, '0, '0, minus_one);        // south pole, behind
    send_star(half, -half, minus_one, '0, '0, minus_one);  // south pole
    send_star(one, half, '0, one, '0, one);                // pole, zero divisor
    send_star('0, '0, '0, half, '0, one);                  // pole, zero numerators, behind
    send_star(half, half, half, '0, '0, half);             // axis centre, not a pole
    send_star(minus_one, '0, '0, one, '0, '0);             // directly behind
    send_star(one, one, one, one, one, one);               // all components one
    send_star(minus_one, minus_one, minus_one, minus_one, minus_one, minus_one);
    send_star(32'd1, one, '0, one, '0, '0);                // grazing star
    send_star(32'd1, minus_one, minus_one, one, '0, '0);   // negative saturation
    send_star(half, half, -half, half, half, '0);          // equator centre
    send_star(one, '0, '0, one, '0, '0);                   // star at centre
    send_star(32'h3fff_ffff, 32'hc000_0001, 32'h1, 32'h3fff_ffff, 32'hc000_0001, 32'h1);
    // Full-scale bit patterns well outside the unit sphere.
    send_star(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_star(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);

    // Hold off until everything directed is back.
    wait_drained();

    for (int i = 0; i < 1450; i++) begin
      idle_en = !(i >= 400 && i < 700);
      send_random();
    end

    wait_drained();
    repeat (200) @(posedge clk);
    $display("Checked %0d projections: %0d behind the centre, %0d saturated, %0d at a pole.",
             board.n_checked, board.n_behind, board.n_sat, board.n_pole);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
